// File: hdl/irle_pkg.sv
// Shared constants and types for the image row run-length encoder.
`default_nettype none
package irle_pkg;

  localparam int MAX_COLS   = 4096;
  localparam int MAX_ROWS   = 4096;
  localparam int PIXEL_BITS = 16;

  localparam int COL_W = 12;
  localparam int ROW_W = 12;
  localparam int LEN_W = 13;
  localparam int CFG_W = 13;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 2'd1;

  localparam int OUT_FIELDS_W = ROW_W + COL_W + PIXEL_BITS + LEN_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = Q_PTR_W + 1;

  typedef struct packed {
    logic [COL_W-1:0]      start;
    logic [PIXEL_BITS-1:0] value;
    logic [LEN_W-1:0]      length;
  } run_rec_t;

  // One queue entry: every run closed by one pixel
  typedef struct packed {
    logic             two;
    logic [ROW_W-1:0] row;
    run_rec_t         rec0;
    run_rec_t         rec1;
  } q_entry_t;

  typedef struct packed {
    logic     push;
    q_entry_t entry;
  } q_push_t;

endpackage
`default_nettype wire

// File: hdl/irle_front.sv
// Front end: pixel intake, config registers, run tracking and run closing.
`default_nettype none
module irle_front (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output      logic                           in_tready,
  input  wire logic [15:0]                    in_tdata,   // [15:0] pixel
  input  wire logic                           cfg_valid,
  output      logic                           cfg_ready,
  input  wire logic [irle_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [irle_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic                           q_full,
  output      irle_pkg::q_push_t              q_push
);

  logic [irle_pkg::CFG_W-1:0]      width_r, count_r;
  logic [irle_pkg::COL_W-1:0]      col_r;
  logic [irle_pkg::ROW_W-1:0]      row_r;
  logic                            open_r;
  logic [irle_pkg::PIXEL_BITS-1:0] val_r;
  logic [irle_pkg::COL_W-1:0]      start_r;
  logic [irle_pkg::LEN_W-1:0]      len_r;

  logic [irle_pkg::CFG_W-1:0]      w_clamp, h_clamp, w_m1, h_m1;
  logic [irle_pkg::PIXEL_BITS-1:0] pix;
  logic                            accept, row_end, match, emit_old, start_new, close_end;
  logic                            open_nxt;
  irle_pkg::run_rec_t              cur_rec, new_rec, old_rec;

  always_comb begin
    if (width_r == '0) begin
      w_clamp = irle_pkg::CFG_W'(1);
    end else if (width_r > irle_pkg::CFG_W'(irle_pkg::MAX_COLS)) begin
      w_clamp = irle_pkg::CFG_W'(irle_pkg::MAX_COLS);
    end else begin
      w_clamp = width_r;
    end
    if (count_r == '0) begin
      h_clamp = irle_pkg::CFG_W'(1);
    end else if (count_r > irle_pkg::CFG_W'(irle_pkg::MAX_ROWS)) begin
      h_clamp = irle_pkg::CFG_W'(irle_pkg::MAX_ROWS);
    end else begin
      h_clamp = count_r;
    end
  end

  assign w_m1      = w_clamp - irle_pkg::CFG_W'(1);
  assign h_m1      = h_clamp - irle_pkg::CFG_W'(1);
  assign pix       = in_tdata[irle_pkg::PIXEL_BITS-1:0];
  assign in_tready = !q_full;
  assign cfg_ready = 1'b1;
  assign accept    = in_tvalid && !q_full;

  assign row_end   = {1'b0, col_r} >= w_m1;
  assign match     = open_r && (pix == val_r);
  assign emit_old  = open_r && !match;
  assign start_new = !match && (pix != '0);
  assign close_end = row_end && (match || start_new);
  assign open_nxt  = (match || start_new) && !row_end;

  assign old_rec = irle_pkg::run_rec_t'{start: start_r, value: val_r, length: len_r};
  assign new_rec = irle_pkg::run_rec_t'{start: col_r, value: pix,
                                        length: irle_pkg::LEN_W'(1)};
  assign cur_rec = match ? irle_pkg::run_rec_t'{start: start_r, value: val_r,
                                                length: len_r + irle_pkg::LEN_W'(1)}
                         : new_rec;

  always_comb begin
    q_push.push        = accept && (emit_old || close_end);
    q_push.entry.row   = row_r;
    q_push.entry.two   = emit_old && close_end;
    q_push.entry.rec0  = emit_old ? old_rec : cur_rec;
    q_push.entry.rec1  = new_rec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= irle_pkg::CFG_W'(irle_pkg::MAX_COLS);
      count_r <= irle_pkg::CFG_W'(irle_pkg::MAX_ROWS);
      col_r   <= '0;
      row_r   <= '0;
      open_r  <= 1'b0;
      val_r   <= '0;
      start_r <= '0;
      len_r   <= '0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == irle_pkg::REG_ROW_WIDTH) begin
          width_r <= cfg_data;
        end else if (cfg_index == irle_pkg::REG_ROW_COUNT) begin
          count_r <= cfg_data;
        end
      end
      if (accept) begin
        open_r <= open_nxt;
        if (match) begin
          len_r <= len_r + irle_pkg::LEN_W'(1);
        end else if (start_new) begin
          val_r   <= pix;
          start_r <= col_r;
          len_r   <= irle_pkg::LEN_W'(1);
        end
        if (row_end) begin
          col_r <= '0;
          if ({1'b0, row_r} >= h_m1) begin
            row_r <= '0;
          end else begin
            row_r <= row_r + irle_pkg::ROW_W'(1);
          end
        end else begin
          col_r <= col_r + irle_pkg::COL_W'(1);
        end
      end
    end
  end

endmodule
`default_nettype wire

// File: hdl/irle_queue.sv
// Short queue of closed-run entries between front and back ends.
`default_nettype none
module irle_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire irle_pkg::q_push_t  q_push,
  output      logic               full,
  input  wire logic               pop,
  output      logic               empty,
  output      irle_pkg::q_entry_t rd_entry
);

  irle_pkg::q_entry_t             mem [irle_pkg::Q_DEPTH];
  logic [irle_pkg::Q_PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [irle_pkg::Q_CNT_W-1:0]   cnt_r;

  assign full     = cnt_r == irle_pkg::Q_CNT_W'(irle_pkg::Q_DEPTH);
  assign empty    = cnt_r == '0;
  assign rd_entry = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (q_push.push) begin
      mem[wr_ptr_r] <= q_push.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (q_push.push) begin
        wr_ptr_r <= wr_ptr_r + irle_pkg::Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + irle_pkg::Q_PTR_W'(1);
      end
      if (q_push.push && !pop) begin
        cnt_r <= cnt_r + irle_pkg::Q_CNT_W'(1);
      end else if (!q_push.push && pop) begin
        cnt_r <= cnt_r - irle_pkg::Q_CNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

// File: hdl/irle_back.sv
// Back end: splits queue entries into single runs and drives the output register.
`default_nettype none
module irle_back (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             empty,
  input  wire irle_pkg::q_entry_t               rd_entry,
  output      logic                             pop,
  output      logic                             out_tvalid,
  input  wire logic                             out_tready,
  output      logic [irle_pkg::OUT_TDATA_W-1:0] out_tdata,
  output      logic                             out_tlast
);

  logic                         out_valid_r, last_r, sel_r;
  logic [irle_pkg::ROW_W-1:0]   row_r;
  irle_pkg::run_rec_t           rec_r, rec_sel;
  logic                         load, last_sel;

  assign load     = !empty && (!out_valid_r || out_tready);
  assign rec_sel  = sel_r ? rd_entry.rec1 : rd_entry.rec0;
  assign last_sel = sel_r || !rd_entry.two;
  assign pop      = load && last_sel;

  assign out_tvalid = out_valid_r;
  assign out_tlast  = last_r;
  assign out_tdata  = {(irle_pkg::OUT_TDATA_W - irle_pkg::OUT_FIELDS_W)'(0),
                       rec_r.length, rec_r.value, rec_r.start, row_r};

  always_ff @(posedge clk) begin
    if (load) begin
      rec_r  <= rec_sel;
      row_r  <= rd_entry.row;
      last_r <= last_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sel_r       <= 1'b0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        sel_r       <= !last_sel;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// File: hdl/image_row_run_length_encoder.sv
// Top level of the image row run-length encoder.
// A run's record enters the queue when its closing pixel is taken, then the output register.
// Throughput: one pixel per cycle while the queue is not full; one output transfer per
// cycle while out_tready is high; the four-entry queue absorbs a pixel closing two runs.
// Reset (synchronous, rst_n low): counters, open run and queue clear; registers go to 4096.
`default_nettype none
module image_row_run_length_encoder (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output      logic                             in_tready,
  input  wire logic [15:0]                      in_tdata,   // [15:0] pixel
  output      logic                             out_tvalid,
  input  wire logic                             out_tready,
  // [11:0] run_row, [23:12] run_start_col, [39:24] run_value, [52:40] run_length
  output      logic [irle_pkg::OUT_TDATA_W-1:0] out_tdata,
  output      logic                             out_tlast,  // last_of_item
  input  wire logic                             cfg_valid,
  output      logic                             cfg_ready,
  input  wire logic [irle_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [irle_pkg::CFG_W-1:0]       cfg_data
);

  irle_pkg::q_push_t  q_push;
  irle_pkg::q_entry_t rd_entry;
  logic               q_full, q_empty, q_pop;

  irle_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push)
  );

  irle_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_push   (q_push),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .rd_entry (rd_entry)
  );

  irle_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .empty      (q_empty),
    .rd_entry   (rd_entry),
    .pop        (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire

// File: hdl/irle_checker.sv
// Port-level checker for the image row run-length encoder, bound to the top level.
`default_nettype none
module irle_checker (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             out_tvalid,
  input wire logic                             out_tready,
  input wire logic [irle_pkg::OUT_TDATA_W-1:0] out_tdata,
  input wire logic                             out_tlast
);

  logic [13:0] run_end;

  assign run_end = {2'b00, out_tdata[23:12]} + {1'b0, out_tdata[52:40]};

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output changed while stalled");

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  a_run_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[52:40] != '0 && out_tdata[39:24] != '0)
    else $error("empty or background run emitted");

  a_run_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> run_end <= 14'd4096)
    else $error("run extends past the row");

endmodule

bind image_row_run_length_encoder irle_checker u_irle_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
`default_nettype wire
